/* sv/patlb_pkg.sv */
// Shared types, widths, codes and helpers for the paged address translation block.
`default_nettype none

package patlb_pkg;

   // Field widths of the transaction payloads.
   localparam int TYPE_W   = 2;
   localparam int ADDR_W   = 31;
   localparam int INDEX_W  = 6;
   localparam int PAGE_W   = 31;
   localparam int FRAME_W  = 16;
   localparam int OFFSET_W = 16;
   localparam int PS_W     = 17;
   localparam int PHYS_W   = 32;
   localparam int STATUS_W = 2;

   // Width that holds any entry index plus one, used for scan counters.
   localparam int IDXC_W = INDEX_W + 1;

   // Divider step counter width (one step per address bit).
   localparam int DIV_CNT_W = 5;

   // Page size register reset value and legal range limits.
   localparam logic [PS_W-1:0] PS_RESET = 17'd4096;
   localparam logic [PS_W-1:0] PS_MAX   = 17'h10000;
   localparam logic [PS_W-1:0] PS_MIN   = 17'd1;

   // Request codes.
   typedef enum logic [TYPE_W-1:0] {
      REQ_TRANSLATE = 2'd0,
      REQ_WRITE_PT  = 2'd1,
      REQ_WRITE_TLB = 2'd2,
      REQ_UNUSED    = 2'd3
   } req_code_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_TRANSLATED = 2'd0,
      ST_NOT_LOADED = 2'd1,
      ST_NO_ENTRY   = 2'd2,
      ST_WRITE_DONE = 2'd3
   } status_code_type;

   // One table entry as written to and read from a table.
   typedef struct packed {
      logic               valid;
      logic               present;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
   } entry_type;

   // Clamp the configured page size into the range that the datapath supports.
   function automatic logic [PS_W-1:0] eff_pg_size(input logic [PS_W-1:0] ps);
      logic [PS_W-1:0] result;
      if (ps == '0) begin
         result = PS_MIN;
      end else if (ps > PS_MAX) begin
         result = PS_MAX;
      end else begin
         result = ps;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

/* sv/patlb_divider.sv */
// Restoring divider that splits an address into page number and offset, one bit per cycle.
`default_nettype none

module patlb_divider
   import patlb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [ADDR_W-1:0]   dividend,
   input  wire logic [PS_W-1:0]     divisor,
   output logic                     done,
   output logic [ADDR_W-1:0]        quotient,
   output logic [OFFSET_W-1:0]      remainder
);

   logic [ADDR_W-1:0]    quo_ff;
   logic [PS_W-1:0]      rem_ff;
   logic [PS_W-1:0]      dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 run_ff;
   logic                 done_ff;

   logic [PS_W:0]        rem_shift;
   logic                 rem_ge;
   logic [PS_W:0]        rem_sub;

   // Shift in the next dividend bit and try to subtract the divisor.
   assign rem_shift = {rem_ff, quo_ff[ADDR_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, dsr_ff});
   assign rem_sub   = rem_shift - {1'b0, dsr_ff};

   // Control state of the iteration.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(ADDR_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: quotient bits shift in as dividend bits shift out.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[ADDR_W-2:0], rem_ge};
         rem_ff <= rem_ge ? rem_sub[PS_W-1:0] : rem_shift[PS_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[OFFSET_W-1:0];

endmodule

`default_nettype wire

/* sv/patlb_table.sv */
// Translation table storage: synchronous entry memory with valid bits in flip-flops.
`default_nettype none

module patlb_table
   import patlb_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_entry,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_entry
);

   localparam int DATA_W = 1 + PAGE_W + FRAME_W;

   logic [DATA_W-1:0]  mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [DATA_W-1:0]  rd_data_ff;
   logic               rd_valid_ff;

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_entry.present, wr_entry.page, wr_entry.frame};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Valid bits clear at reset; an entry becomes valid only with its data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= wr_entry.valid;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry.valid   = rd_valid_ff;
   assign rd_entry.present = rd_data_ff[DATA_W-1];
   assign rd_entry.page    = rd_data_ff[PAGE_W+FRAME_W-1:FRAME_W];
   assign rd_entry.frame   = rd_data_ff[FRAME_W-1:0];

endmodule

`default_nettype wire

/* sv/paged_address_translate_tlb_unit.sv */
// Top level of the paged address translation block with TLB and page table.
//
// A transaction is taken when start is high and busy is low; each one produces exactly one
// result, shown on the rsp_ ports for a single cycle while rsp_valid is high, and the
// receiver must take it then. Table writes are done at the accepting edge and the result
// follows on the next cycle, so writes can be issued back to back. A translation first loads
// the serial divider and runs its 31 steps, one quotient bit each, then scans the TLB memory
// one entry per cycle, comparing each entry the cycle after its read and stopping at the
// first match, then on a miss scans the page table the same way, then registers the frame
// multiply in S_MUL when found and forms the result in S_ADD; busy drops in the cycle that
// the result is on the ports. The page size register is written through the csr_ port,
// which is ready whenever busy is low and start is low.
`default_nettype none

module paged_address_translate_tlb_unit
   import patlb_pkg::*;
#(
   parameter int PT_ENTRIES  = 64,
   parameter int TLB_ENTRIES = 16
)
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                start,
   output logic                     busy,
   input  wire logic [TYPE_W-1:0]   req_type,
   input  wire logic [ADDR_W-1:0]   req_logical_address,
   input  wire logic [INDEX_W-1:0]  req_entry_index,
   input  wire logic [PAGE_W-1:0]   req_entry_page,
   input  wire logic [FRAME_W-1:0]  req_entry_frame,
   input  wire logic                req_entry_present,
   input  wire logic                req_entry_valid,

   output logic                     rsp_valid,
   output logic [PAGE_W-1:0]        rsp_page_num,
   output logic [OFFSET_W-1:0]      rsp_page_offset,
   output logic                     rsp_tlb_hit,
   output logic                     rsp_found,
   output logic [FRAME_W-1:0]       rsp_frame,
   output logic [PHYS_W-1:0]        rsp_phys_addr,
   output logic [STATUS_W-1:0]      rsp_status,

   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [PS_W-1:0]     csr_pg_size
);

   localparam int PT_AW  = (PT_ENTRIES > 1) ? $clog2(PT_ENTRIES) : 1;
   localparam int TLB_AW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam logic [IDXC_W-1:0] PT_N  = IDXC_W'(PT_ENTRIES);
   localparam logic [IDXC_W-1:0] TLB_N = IDXC_W'(TLB_ENTRIES);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIV  = 6'b000010,
      S_TLB  = 6'b000100,
      S_PT   = 6'b001000,
      S_MUL  = 6'b010000,
      S_ADD  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [IDXC_W-1:0]     cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   logic [PAGE_W-1:0]     pnum_ff, pnum_in;
   logic [OFFSET_W-1:0]   poff_ff, poff_in;
   logic [FRAME_W-1:0]    frame_ff, frame_in;
   logic                  hit_ff, hit_in;
   logic                  found_ff, found_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [PHYS_W-1:0]     prod_ff, prod_in;
   logic [PS_W-1:0]       ps_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]     rsp_pnum_ff, rsp_pnum_in;
   logic [OFFSET_W-1:0]   rsp_poff_ff, rsp_poff_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [FRAME_W-1:0]    rsp_frame_ff, rsp_frame_in;
   logic [PHYS_W-1:0]     rsp_phys_ff, rsp_phys_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic [PS_W-1:0]       ps_eff;
   logic [PHYS_W-1:0]     mul_full;
   logic                  div_start;
   logic                  div_done;
   logic [ADDR_W-1:0]     div_quo;
   logic [OFFSET_W-1:0]   div_rem;

   logic                  pt_wr_en;
   logic                  tlb_wr_en;
   entry_type             wr_entry;
   entry_type             pt_rd;
   entry_type             tlb_rd;

   // Handshakes. The page size cannot change at the edge that starts a translation.
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy && !start;

   // Page size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff <= PS_RESET;
      end else if (csr_valid && csr_ready) begin
         ps_ff <= csr_pg_size;
      end
   end

   assign ps_eff = eff_pg_size(ps_ff);

   // Table writes happen at the edge that accepts the write transaction.
   assign wr_entry.valid   = req_entry_valid;
   assign wr_entry.present = req_entry_present;
   assign wr_entry.page    = req_entry_page;
   assign wr_entry.frame   = req_entry_frame;

   assign pt_wr_en  = accept && (req_type == REQ_WRITE_PT)
                      && ({1'b0, req_entry_index} < PT_N);
   assign tlb_wr_en = accept && (req_type == REQ_WRITE_TLB)
                      && ({1'b0, req_entry_index} < TLB_N);

   patlb_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_logical_address),
      .divisor   (ps_eff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   patlb_table #(
      .ENTRIES (TLB_ENTRIES),
      .AW      (TLB_AW)
   ) u_tlb (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tlb_wr_en),
      .wr_addr  (req_entry_index[TLB_AW-1:0]),
      .wr_entry (wr_entry),
      .rd_addr  (cnt_ff[TLB_AW-1:0]),
      .rd_entry (tlb_rd)
   );

   patlb_table #(
      .ENTRIES (PT_ENTRIES),
      .AW      (PT_AW)
   ) u_pt (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pt_wr_en),
      .wr_addr  (req_entry_index[PT_AW-1:0]),
      .wr_entry (wr_entry),
      .rd_addr  (cnt_ff[PT_AW-1:0]),
      .rd_entry (pt_rd)
   );

   // Frame times page size, registered before the offset is added.
   assign mul_full = PHYS_W'(frame_ff) * PHYS_W'(ps_eff);

   // Sequencer: writes answer from idle; translations divide, scan TLB, scan page table, multiply, emit.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pnum_in       = pnum_ff;
      poff_in       = poff_ff;
      frame_in      = frame_ff;
      hit_in        = hit_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      prod_in       = prod_ff;
      div_start     = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_pnum_in   = rsp_pnum_ff;
      rsp_poff_in   = rsp_poff_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_phys_in   = rsp_phys_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_type == REQ_TRANSLATE) begin
                  div_start = 1'b1;
                  hit_in    = 1'b0;
                  found_in  = 1'b0;
                  frame_in  = '0;
                  status_in = ST_NO_ENTRY;
                  state_in  = S_DIV;
               end else begin
                  // Write and unused codes answer at once with write done.
                  rsp_valid_in  = 1'b1;
                  rsp_pnum_in   = '0;
                  rsp_poff_in   = '0;
                  rsp_hit_in    = 1'b0;
                  rsp_found_in  = 1'b0;
                  rsp_frame_in  = '0;
                  rsp_phys_in   = '0;
                  rsp_status_in = ST_WRITE_DONE;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               pnum_in  = div_quo;
               poff_in  = div_rem;
               cnt_in   = '0;
               state_in = S_TLB;
            end
         end
         S_TLB: begin
            // Issue one read per cycle and compare the entry read last cycle.
            if (cnt_ff < TLB_N) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + IDXC_W'(1);
            end
            if (pend_ff && tlb_rd.valid && (tlb_rd.page == pnum_ff)) begin
               hit_in    = 1'b1;
               found_in  = 1'b1;
               frame_in  = tlb_rd.frame;
               status_in = ST_TRANSLATED;
               pend_in   = 1'b0;
               state_in  = S_MUL;
            end else if (!pend_ff && (cnt_ff == TLB_N)) begin
               cnt_in   = '0;
               state_in = S_PT;
            end
         end
         S_PT: begin
            if (cnt_ff < PT_N) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + IDXC_W'(1);
            end
            if (pend_ff && pt_rd.valid && (pt_rd.page == pnum_ff)) begin
               pend_in = 1'b0;
               if (pt_rd.present) begin
                  found_in  = 1'b1;
                  frame_in  = pt_rd.frame;
                  status_in = ST_TRANSLATED;
                  state_in  = S_MUL;
               end else begin
                  status_in = ST_NOT_LOADED;
                  state_in  = S_ADD;
               end
            end else if (!pend_ff && (cnt_ff == PT_N)) begin
               state_in = S_ADD;
            end
         end
         S_MUL: begin
            prod_in  = mul_full;
            state_in = S_ADD;
         end
         S_ADD: begin
            rsp_valid_in  = 1'b1;
            rsp_pnum_in   = pnum_ff;
            rsp_poff_in   = poff_ff;
            rsp_hit_in    = hit_ff;
            rsp_found_in  = found_ff;
            rsp_frame_in  = frame_ff;
            rsp_phys_in   = found_ff ? (prod_ff + PHYS_W'(poff_ff)) : '0;
            rsp_status_in = status_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      pnum_ff       <= pnum_in;
      poff_ff       <= poff_in;
      frame_ff      <= frame_in;
      hit_ff        <= hit_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      prod_ff       <= prod_in;
      rsp_pnum_ff   <= rsp_pnum_in;
      rsp_poff_ff   <= rsp_poff_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_page_num    = rsp_pnum_ff;
   assign rsp_page_offset = rsp_poff_ff;
   assign rsp_tlb_hit     = rsp_hit_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_frame       = rsp_frame_ff;
   assign rsp_phys_addr   = rsp_phys_ff;
   assign rsp_status      = rsp_status_ff;

   // A found translation always reports the translated status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_TRANSLATED))
      else $error("found translation with wrong status");

   // A failed lookup or a write reports a zero frame and address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         ((rsp_phys_addr == '0) && (rsp_frame == '0)))
      else $error("nonzero frame or address without a translation");

   // A TLB hit implies the translation succeeded.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tlb_hit) |-> rsp_found)
      else $error("TLB hit reported without a found page");

   // An accepted translate transaction holds the block busy and yields no result next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_TRANSLATE)) |=> (busy && !rsp_valid))
      else $error("translate transaction did not start the sequencer");

endmodule

`default_nettype wire
